// ===== rtl/mccs_pkg.sv =====
// Shared types and constants for the minimum coin change solver.
// Used by the controller, the datapath and the top level.
package mccs_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;
  localparam int COIN_W     = 10;
  localparam int CNT_W      = 11;
  localparam int REG_IDX_W  = 4;

  // all-ones count marks a sum that no coins can reach
  localparam logic [CNT_W-1:0] NO_WAY = '1;

  typedef logic [COIN_W-1:0] coin_t;

  // one table entry: least coin count and slot of the last coin
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;        // capture request, clear tallies
    logic init_wr;      // write table entry zero, restart the sum
    logic fill_step;    // one slot phase of the table fill
    logic tb_read;      // read the entry of the current sum
    logic tb_use;       // count its coin and step the sum down
    logic emit_step;    // scan one tally for the output
    logic single_load;  // load a lone result with no coins
    logic single_found; // found bit of that lone result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic target_zero;
    logic target_over;
    logic fill_done;
    logic tb_unreach;
    logic tb_last;
    logic any_tally;
    logic emit_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/mccs_ctrl.sv =====
// Sequencing state machine of the minimum coin change solver.
// Depends on mccs_pkg for the command and status structs.
module mccs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mccs_pkg::status_t  status,
  output mccs_pkg::cmd_t     cmd
);
  import mccs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_FILL,
    S_TB_READ,
    S_TB_USE,
    S_EMIT,
    S_ONE_HIT,
    S_ONE_MISS
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        if (status.target_zero) begin
          state_next = S_ONE_HIT;
        end else if (status.target_over) begin
          state_next = S_ONE_MISS;
        end else begin
          cmd.init_wr = 1'b1;
          state_next  = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_done) begin
          state_next = S_TB_READ;
        end
      end
      S_TB_READ: begin
        cmd.tb_read = 1'b1;
        state_next  = S_TB_USE;
      end
      S_TB_USE: begin
        cmd.tb_use = 1'b1;
        if (status.tb_unreach) begin
          state_next = S_ONE_MISS;
        end else if (status.tb_last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_TB_READ;
        end
      end
      S_EMIT: begin
        // no coin counted: report a found result with no coins
        if (!status.any_tally) begin
          state_next = S_ONE_HIT;
        end else begin
          cmd.emit_step = 1'b1;
          if (status.emit_done) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ONE_HIT: begin
        cmd.single_load  = 1'b1;
        cmd.single_found = 1'b1;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_ONE_MISS: begin
        cmd.single_load = 1'b1;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mccs_datapath.sv =====
// Datapath of the minimum coin change solver: coin registers, count table
// memory, fill compare, traceback tallies and output register. Uses mccs_pkg.
module mccs_datapath #(
  parameter int MAX_TARGET = 1023,
  parameter int NUM_SLOTS  = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [mccs_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [mccs_pkg::COIN_W-1:0]      wr_data,
  input  logic [mccs_pkg::COIN_W-1:0]      target_sum,
  input  mccs_pkg::cmd_t                   cmd,
  output mccs_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [mccs_pkg::SLOT_W-1:0]      slot_index,
  output logic [mccs_pkg::COIN_W-1:0]      coin_value,
  output logic [mccs_pkg::COIN_W-1:0]      coin_count,
  output logic                             last
);
  import mccs_pkg::*;

  localparam int DEPTH = MAX_TARGET + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(NUM_SLOTS + 1);
  localparam logic [PW-1:0] LAST_PHASE = PW'(NUM_SLOTS);

  coin_t              coin [SLOT_COUNT];
  logic [COIN_W-1:0]  tally [SLOT_COUNT];
  entry_t             table_mem [DEPTH];

  logic [COIN_W-1:0]  target;
  logic [COIN_W-1:0]  sum;
  logic [PW-1:0]      phase;
  logic [CNT_W-1:0]   best;
  logic [SLOT_W-1:0]  pick;
  logic               rd_use;
  logic [SLOT_W-1:0]  rd_slot;
  entry_t             rd_data;
  logic [SLOT_W-1:0]  idx;

  // fill
  logic [SLOT_W-1:0]  slot_p;
  coin_t              coin_p;
  logic               use_p;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   best_base;
  logic [SLOT_W-1:0]  pick_base;
  logic               cand_ok;
  logic [CNT_W-1:0]   best_next;
  logic [SLOT_W-1:0]  pick_next;
  logic               phase_end;

  // memory port
  logic               mem_we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [AW-1:0]      raddr;

  // traceback and emission
  coin_t              tb_coin;
  logic               tb_ok;
  logic               tb_count;
  logic               out_free;
  logic               later;
  logic               emit_fire;
  logic               emit_adv;

  // ---------------------------------------------------------------- fill
  assign slot_p    = SLOT_W'(phase);
  assign coin_p    = coin[slot_p];
  assign use_p     = (phase < LAST_PHASE) && (coin_p != '0) && (coin_p <= sum);
  assign phase_end = (phase == LAST_PHASE);
  assign cnt_inc   = rd_data.count + CNT_W'(1);

  always_comb begin
    best_base = (phase == '0) ? NO_WAY : best;
    pick_base = (phase == '0) ? '0 : pick;
    // strict compare keeps the lowest slot on a tie
    cand_ok   = rd_use && (phase != '0) && (rd_data.count != NO_WAY) && (cnt_inc < best_base);
    best_next = cand_ok ? cnt_inc : best_base;
    pick_next = cand_ok ? rd_slot : pick_base;
  end

  assign mem_we = cmd.init_wr || (cmd.fill_step && phase_end);
  assign waddr  = cmd.init_wr ? '0 : AW'(sum);
  assign wdata  = cmd.init_wr ? entry_t'{count: '0, slot: '0}
                              : entry_t'{count: best_next, slot: pick_next};
  assign raddr  = cmd.tb_read ? AW'(sum) : AW'(sum - coin_p);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[waddr] <= wdata;
    end
    rd_data <= table_mem[raddr];
  end

  // ----------------------------------------------------------- traceback
  assign tb_coin  = coin[rd_data.slot];
  assign tb_ok    = (tb_coin != '0) && (tb_coin <= sum);
  assign tb_count = cmd.tb_use && (rd_data.count != NO_WAY) && tb_ok;

  // ------------------------------------------------------------ emission
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if ((SLOT_W'(j) > idx) && (tally[j] != '0)) begin
        later = 1'b1;
      end
    end
  end

  assign emit_fire = cmd.emit_step && (tally[idx] != '0) && out_free;
  assign emit_adv  = cmd.emit_step && ((tally[idx] == '0) || out_free);

  // -------------------------------------------------------------- status
  always_comb begin
    status             = '0;
    status.target_zero = (target == '0);
    status.target_over = (32'(target) > 32'(MAX_TARGET));
    status.fill_done   = phase_end && (sum == target);
    status.tb_unreach  = (rd_data.count == NO_WAY);
    status.tb_last     = !tb_ok || (tb_coin == sum);
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (tally[j] != '0) begin
        status.any_tally = 1'b1;
      end
    end
    status.emit_done   = emit_fire && !later;
    status.out_free    = out_free;
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        coin[j]  <= '0;
        tally[j] <= '0;
      end
      phase     <= '0;
      rd_use    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en && (wr_index < REG_IDX_W'(SLOT_COUNT))) begin
        coin[SLOT_W'(wr_index)] <= wr_data;
      end

      if (cmd.start) begin
        target <= target_sum;
        idx    <= '0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
          tally[j] <= '0;
        end
      end

      if (cmd.init_wr) begin
        sum   <= COIN_W'(1);
        phase <= '0;
      end

      rd_use  <= cmd.fill_step && use_p;
      rd_slot <= slot_p;

      if (cmd.fill_step) begin
        best <= best_next;
        pick <= pick_next;
        if (phase_end) begin
          phase <= '0;
          // hold the sum at the target for the traceback
          if (sum != target) begin
            sum <= sum + COIN_W'(1);
          end
        end else begin
          phase <= phase + PW'(1);
        end
      end

      if (tb_count) begin
        tally[rd_data.slot] <= tally[rd_data.slot] + COIN_W'(1);
        sum                 <= sum - tb_coin;
      end

      if (emit_adv) begin
        idx <= idx + SLOT_W'(1);
      end

      if (emit_fire) begin
        out_valid  <= 1'b1;
        found      <= 1'b1;
        slot_index <= idx;
        coin_value <= coin[idx];
        coin_count <= tally[idx];
        last       <= !later;
      end else if (cmd.single_load && out_free) begin
        out_valid  <= 1'b1;
        found      <= cmd.single_found;
        slot_index <= '0;
        coin_value <= '0;
        coin_count <= '0;
        last       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/min_coin_change_solver_top.sv =====
// Minimum coin change solver: one request takes a target sum and yields a
// shortest coin combination over up to eight configured denominations.
// The table fill steps through NUM_SLOTS+1 phases per sum, set by the single
// read port of the count table (one slot read per phase, then the write);
// the traceback reads and then uses one table entry per coin, and emission
// scans the tallies slot by slot. Requests are taken one at a time; the last
// result of one request may still wait in the output register while the next
// request is accepted. The table needs no clearing.
// Depends on mccs_pkg, mccs_ctrl and mccs_datapath.
module min_coin_change_solver_top #(
  parameter int MAX_TARGET = 1023,
  parameter int NUM_SLOTS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [mccs_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [mccs_pkg::COIN_W-1:0]    wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mccs_pkg::COIN_W-1:0]    target_sum,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [mccs_pkg::SLOT_W-1:0]    slot_index,
  output logic [mccs_pkg::COIN_W-1:0]    coin_value,
  output logic [mccs_pkg::COIN_W-1:0]    coin_count,
  output logic                           last
);
  import mccs_pkg::*;

  cmd_t    cmd;
  status_t status;

  mccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mccs_datapath #(
    .MAX_TARGET (MAX_TARGET),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .target_sum (target_sum),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .slot_index (slot_index),
    .coin_value (coin_value),
    .coin_count (coin_count),
    .last       (last)
  );

  // a taken request keeps the input side busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // a not-found result stands alone and carries no coins
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (last && (coin_count == '0) && (coin_value == '0)))
    else $error("not-found result with coins or not last");

  // a reported coin count always names a real denomination
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (coin_count != '0)) |-> (found && (coin_value != '0)))
    else $error("coin count without a denomination");

endmodule
